// ===== sv/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  // Lead byte prefixes and masks
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  localparam int unsigned POINT_W = 21;

  typedef logic [POINT_W-1:0] point_t;
  typedef logic [15:0]        unit_t;
  typedef logic [1:0]         left_t;
  typedef logic [1:0]         fill_t;

  // Number of units held in the result buffer
  localparam fill_t FILL_NONE = 2'd0;
  localparam fill_t FILL_ONE  = 2'd1;
  localparam fill_t FILL_TWO  = 2'd2;

endpackage

// ===== sv/u8u16_byte_if.sv =====
// Byte channel: valid/ready handshake with one UTF-8 byte and an end-of-string flag.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

// ===== sv/u8u16_unit_if.sv =====
// Unit channel: valid/ready handshake with one UTF-16 code unit and a run-last flag.
interface u8u16_unit_if;
  logic                valid;
  logic                ready;
  u8u16_pkg::unit_t    code_unit;
  logic                run_last;

  modport source (output valid, output code_unit, output run_last, input ready);
  modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

// ===== sv/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder top level: byte decode and a two-unit result buffer.
//
//   channel  dir  handshake                     payload
//   in_bus   in   in_bus.valid / in_bus.ready   byte_in[7:0], final_byte
//   out_bus  out  out_bus.valid / out_bus.ready code_unit[15:0], run_last
//
// One byte per cycle while out_bus.ready is high; a byte that completes a supplementary
// code point holds in_bus.ready low until the high surrogate of the pair has been taken.
// Results are registered and appear in the cycle after the byte is accepted.
// Reset (synchronous, rst_n low) clears the sequence state and empties the buffer.
// A stalled output holds in_bus.ready low only once the buffer cannot drain this cycle.
module utf8_to_utf16_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  u8u16_byte_if.sink           in_bus,
  u8u16_unit_if.source         out_bus
);

  u8u16_pkg::point_t point_r, point_nxt;
  u8u16_pkg::left_t  left_r,  left_nxt;
  logic              bad_r,   bad_nxt;

  u8u16_pkg::fill_t  fill_r,  fill_nxt;
  u8u16_pkg::unit_t  unit0_r, unit0_nxt;
  u8u16_pkg::unit_t  unit1_r, unit1_nxt;
  logic              last0_r, last0_nxt;

  logic              in_fire, out_fire;
  logic              emit;
  u8u16_pkg::point_t cp;
  u8u16_pkg::point_t cp_off;
  logic [7:0]        b;

  assign b        = in_bus.byte_in;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign in_bus.ready = (fill_r == u8u16_pkg::FILL_NONE) ||
                        ((fill_r == u8u16_pkg::FILL_ONE) && out_bus.ready);
  assign in_fire  = in_bus.valid && in_bus.ready;

  assign out_bus.valid     = (fill_r != u8u16_pkg::FILL_NONE);
  assign out_bus.code_unit = unit0_r;
  assign out_bus.run_last  = last0_r;

  // Sequence decode
  always_comb begin
    point_nxt = point_r;
    left_nxt  = left_r;
    bad_nxt   = bad_r;
    emit      = 1'b0;
    cp        = point_r;
    if (left_r == 2'd0) begin
      priority if ((b & u8u16_pkg::ASCII_MASK) == 8'h00) begin
        emit = 1'b1;
        cp   = {13'd0, b};
      end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
        point_nxt = {16'd0, b[4:0]};
        left_nxt  = 2'd1;
        bad_nxt   = 1'b0;
      end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
        point_nxt = {17'd0, b[3:0]};
        left_nxt  = 2'd2;
        bad_nxt   = 1'b0;
      end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
        point_nxt = {18'd0, b[2:0]};
        left_nxt  = 2'd3;
        bad_nxt   = 1'b0;
      end else begin
        // skip invalid lead
        point_nxt = point_r;
      end
    end else begin
      bad_nxt   = bad_r | ((b & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG);
      point_nxt = {point_r[14:0], b[5:0]};
      left_nxt  = left_r - 2'd1;
      cp        = point_nxt;
      emit      = (left_nxt == 2'd0) && !bad_nxt;
    end
    if (in_bus.final_byte) begin
      point_nxt = '0;
      left_nxt  = 2'd0;
      bad_nxt   = 1'b0;
    end
  end

  assign cp_off = cp - u8u16_pkg::SUPP_BASE;

  // Result buffer: pop on out_fire, load on in_fire (only when it drains)
  always_comb begin
    fill_nxt  = fill_r;
    unit0_nxt = unit0_r;
    unit1_nxt = unit1_r;
    last0_nxt = last0_r;
    if (out_fire) begin
      fill_nxt  = fill_r - 2'd1;
      unit0_nxt = unit1_r;
      last0_nxt = 1'b1;
    end
    if (in_fire) begin
      if (!emit) begin
        fill_nxt = u8u16_pkg::FILL_NONE;
      end else if (cp[20:16] == 5'd0) begin
        fill_nxt  = u8u16_pkg::FILL_ONE;
        unit0_nxt = cp[15:0];
        last0_nxt = 1'b1;
      end else begin
        fill_nxt  = u8u16_pkg::FILL_TWO;
        unit0_nxt = u8u16_pkg::HI_SURR + {5'd0, cp_off[20:10]};
        unit1_nxt = u8u16_pkg::LO_SURR | {6'd0, cp_off[9:0]};
        last0_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
      left_r  <= 2'd0;
      bad_r   <= 1'b0;
      fill_r  <= u8u16_pkg::FILL_NONE;
    end else begin
      if (in_fire) begin
        point_r <= point_nxt;
        left_r  <= left_nxt;
        bad_r   <= bad_nxt;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit0_r <= unit0_nxt;
    unit1_r <= unit1_nxt;
    last0_r <= last0_nxt;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("result buffer fill out of range");

  // High half spans 0xD800..0xDFBF without range checks on the code point
  a_pair_high_first: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == u8u16_pkg::FILL_TWO) |-> (!out_bus.run_last &&
      out_bus.code_unit[15:11] == 5'h1B))
    else $error("pair head is not a high surrogate");

  a_pair_low_next: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == u8u16_pkg::FILL_TWO && out_bus.ready) |=>
      (out_bus.valid && out_bus.run_last && out_bus.code_unit[15:10] == 6'h37))
    else $error("low surrogate does not follow high surrogate");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.final_byte) |=> (left_r == 2'd0 && !bad_r && point_r == '0))
    else $error("sequence state not cleared at end of string");

endmodule
